>>> rtl/tebal_pkg.sv
package tebal_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned CmdW = 3;
  localparam int unsigned PaddrW = 2;

  localparam logic [AddrW-1:0] LowAlignMask = 32'd63;
  localparam logic [PaddrW-1:0] RegRamEndAddr = 2'd0;

  typedef enum logic [CmdW-1:0] {
    CMD_INIT         = 3'd0,
    CMD_ALLOC_LOW    = 3'd1,
    CMD_ALLOC_ABOVE  = 3'd2,
    CMD_ALLOC_HIGH   = 3'd3,
    CMD_LOW_ALIGNED  = 3'd4,
    CMD_HIGH_ALIGNED = 3'd5,
    CMD_QUERY        = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [AddrW-1:0] alloc_size;
    logic [AddrW-1:0] address_arg;
    logic [AddrW-1:0] align_mask;
    logic [AddrW-1:0] size_plus_mask;
    logic [AddrW-1:0] size_plus_low;
    logic [AddrW-1:0] program_end;
  } req_t;

endpackage

>>> rtl/tebal_apb_regs.sv
module tebal_apb_regs
  import tebal_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [AddrW-1:0]  ram_end
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && (paddr == RegRamEndAddr);

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_end <= '0;
    end else if (wr_en) begin
      ram_end <= pwdata;
    end
  end

  assign prdata = (paddr == RegRamEndAddr) ? ram_end : 32'd0;

endmodule

>>> rtl/tebal_in_stage.sv
module tebal_in_stage
  import tebal_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [CmdW-1:0]  command,
  input  logic [AddrW-1:0] alloc_size,
  input  logic [AddrW-1:0] address_arg,
  input  logic             advance,
  output logic             stage_valid,
  output req_t             stage_req
);

  req_t req_next;

  // operand sums prepared here so the core path stays short
  always_comb begin
    req_next.command        = command;
    req_next.alloc_size     = alloc_size;
    req_next.address_arg    = address_arg;
    req_next.align_mask     = address_arg - 32'd1;
    req_next.size_plus_mask = alloc_size + address_arg - 32'd1;
    req_next.size_plus_low  = alloc_size + LowAlignMask;
    req_next.program_end    = address_arg + alloc_size;
  end

  assign req_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stage_req <= req_next;
    end
  end

endmodule

>>> rtl/tebal_alloc_core.sv
module tebal_alloc_core
  import tebal_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [AddrW-1:0] ram_end,
  input  logic             stage_valid,
  input  req_t             stage_req,
  output logic             advance,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output logic [AddrW-1:0] block_address,
  output logic [AddrW-1:0] free_bytes,
  output logic             marks_crossed
);

  logic [AddrW-1:0] low_mark;
  logic [AddrW-1:0] high_mark;
  logic [AddrW-1:0] low_mark_next;
  logic [AddrW-1:0] high_mark_next;
  logic [AddrW-1:0] addr_next;
  logic [AddrW-1:0] low_base;
  logic [AddrW-1:0] low_mask;
  logic [AddrW-1:0] low_addr;
  logic [AddrW-1:0] high_sub;
  logic [AddrW-1:0] high_mask;
  logic [AddrW-1:0] high_addr;
  cmd_t             cmd;

  assign cmd = cmd_t'(stage_req.command);
  assign advance = stage_valid && (!rsp_valid || rsp_ready);

  always_comb begin
    low_base = ((cmd == CMD_ALLOC_ABOVE) && (low_mark < stage_req.address_arg))
               ? stage_req.address_arg : low_mark;
    low_mask = (cmd == CMD_LOW_ALIGNED) ? stage_req.align_mask : LowAlignMask;
    low_addr = (low_base + low_mask) & ~low_mask;
    high_sub = (cmd == CMD_HIGH_ALIGNED) ? stage_req.size_plus_mask
                                         : stage_req.size_plus_low;
    high_mask = (cmd == CMD_HIGH_ALIGNED) ? stage_req.align_mask : LowAlignMask;
    high_addr = (high_mark - high_sub) & ~high_mask;
  end

  always_comb begin
    low_mark_next  = low_mark;
    high_mark_next = high_mark;
    addr_next      = '0;
    unique case (cmd)
      CMD_INIT: begin
        low_mark_next  = stage_req.program_end;
        high_mark_next = ram_end;
      end
      CMD_ALLOC_LOW, CMD_ALLOC_ABOVE, CMD_LOW_ALIGNED: begin
        addr_next     = low_addr;
        low_mark_next = low_addr + stage_req.alloc_size;
      end
      CMD_ALLOC_HIGH, CMD_HIGH_ALIGNED: begin
        addr_next      = high_addr;
        high_mark_next = high_addr;
      end
      CMD_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_mark  <= '0;
      high_mark <= '0;
      rsp_valid <= 1'b0;
    end else if (advance) begin
      low_mark  <= low_mark_next;
      high_mark <= high_mark_next;
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      block_address <= addr_next;
    end
  end

  // marks only move when a new word is loaded, so these track the held result
  assign free_bytes    = high_mark - low_mark;
  assign marks_crossed = low_mark > high_mark;

endmodule

>>> rtl/two_ended_bump_allocator.sv
// response path: an accepted request is registered in the input register, then in the result register
// throughput: one word per cycle while rsp_ready is held high, limited by the single mark update path
// reset (rst, synchronous, active high): low mark, high mark and ram_end clear
// to zero, both pipeline stages empty
module two_ended_bump_allocator
  import tebal_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [CmdW-1:0]   command,
  input  logic [AddrW-1:0]  alloc_size,
  input  logic [AddrW-1:0]  address_arg,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [AddrW-1:0]  block_address,
  output logic [AddrW-1:0]  free_bytes,
  output logic              marks_crossed
);

  logic [AddrW-1:0] ram_end;
  logic             stage_valid;
  req_t             stage_req;
  logic             advance;

  tebal_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ram_end (ram_end)
  );

  tebal_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .command     (command),
    .alloc_size  (alloc_size),
    .address_arg (address_arg),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_req   (stage_req)
  );

  tebal_alloc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .ram_end       (ram_end),
    .stage_valid   (stage_valid),
    .stage_req     (stage_req),
    .advance       (advance),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .block_address (block_address),
    .free_bytes    (free_bytes),
    .marks_crossed (marks_crossed)
  );

endmodule

>>> dv/tb_top.sv
module tb_top;
  import tebal_pkg::*;

  localparam int CycleLimit = 400000;
  localparam logic [CmdW-1:0] CmdUnused = 3'd7;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [AddrW-1:0] alloc_size;
    logic [AddrW-1:0] address_arg;
  } heap_request_t;

  typedef struct packed {
    logic [AddrW-1:0] block_address;
    logic [AddrW-1:0] free_bytes;
    logic             marks_crossed;
  } heap_outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic [CmdW-1:0]   command = '0;
  logic [AddrW-1:0]  alloc_size = '0;
  logic [AddrW-1:0]  address_arg = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  logic [AddrW-1:0]  block_address;
  logic [AddrW-1:0]  free_bytes;
  logic              marks_crossed;

  two_ended_bump_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .command       (command),
    .alloc_size    (alloc_size),
    .address_arg   (address_arg),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .block_address (block_address),
    .free_bytes    (free_bytes),
    .marks_crossed (marks_crossed)
  );

  heap_request_t pending_requests[$];
  heap_outcome_t expected_outcomes[$];

  logic [AddrW-1:0] low_mark_q = '0;
  logic [AddrW-1:0] high_mark_q = '0;
  logic [AddrW-1:0] ram_end_q = '0;

  int   cycle_cnt = 0;
  int   err_cnt = 0;
  int   items_queued = 0;
  int   items_accepted = 0;
  logic req_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   hold_left = 0;
  int   pattern_left = 0;
  int   stall_style = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic apply_heap_request(input logic [CmdW-1:0] cmd, input logic [AddrW-1:0] size,
                                    input logic [AddrW-1:0] arg);
    logic [AddrW-1:0] blk;
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] mask;
    heap_outcome_t    o;
    blk = '0;
    mask = arg - 32'd1;
    case (cmd)
      CMD_INIT: begin
        low_mark_q = arg + size;
        high_mark_q = ram_end_q;
      end
      CMD_ALLOC_LOW: begin
        blk = (low_mark_q + LowAlignMask) & ~LowAlignMask;
        low_mark_q = blk + size;
      end
      CMD_ALLOC_ABOVE: begin
        base = (low_mark_q < arg) ? arg : low_mark_q;
        blk = (base + LowAlignMask) & ~LowAlignMask;
        low_mark_q = blk + size;
      end
      CMD_ALLOC_HIGH: begin
        blk = (high_mark_q - (size + LowAlignMask)) & ~LowAlignMask;
        high_mark_q = blk;
      end
      CMD_LOW_ALIGNED: begin
        blk = (low_mark_q + mask) & ~mask;
        low_mark_q = blk + size;
      end
      CMD_HIGH_ALIGNED: begin
        blk = (high_mark_q - (size + mask)) & ~mask;
        high_mark_q = blk;
      end
      default: ;
    endcase
    o.block_address = blk;
    o.free_bytes = high_mark_q - low_mark_q;
    o.marks_crossed = (low_mark_q > high_mark_q);
    expected_outcomes.push_back(o);
  endtask

  // request side: bursts with random gaps
  always @(negedge clk) begin
    heap_request_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (gap_left != 0 || pending_requests.size() == 0) begin
        req_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        nxt = pending_requests.pop_front();
        req_valid <= 1'b1;
        command <= nxt.command;
        alloc_size <= nxt.alloc_size;
        address_arg <= nxt.address_arg;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // response side: stall patterns plus a periodic long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left--;
    end else if (cycle_cnt % 1500 == 700) begin
      rsp_ready <= 1'b0;
      hold_left = 150;
    end else begin
      if (pattern_left == 0) begin
        stall_style = $urandom_range(0, 3);
        pattern_left = $urandom_range(10, 80);
      end
      pattern_left--;
      case (stall_style)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= 1'($urandom_range(0, 1));
        2: rsp_ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    heap_outcome_t want;
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      req_taken <= req_valid && req_ready;
      if (!rst) begin
        if (psel && penable && pwrite && pready && paddr == RegRamEndAddr) ram_end_q = pwdata;
        if (req_valid && req_ready) begin
          apply_heap_request(command, alloc_size, address_arg);
          items_accepted++;
        end
        if (rsp_valid && rsp_ready) begin
          if (expected_outcomes.size() == 0) begin
            $error("response word with nothing outstanding");
            err_cnt++;
          end else begin
            want = expected_outcomes.pop_front();
            if (block_address !== want.block_address) begin
              $error("block_address expected %h actual %h", want.block_address, block_address);
              err_cnt++;
            end
            if (free_bytes !== want.free_bytes) begin
              $error("free_bytes expected %h actual %h", want.free_bytes, free_bytes);
              err_cnt++;
            end
            if (marks_crossed !== want.marks_crossed) begin
              $error("marks_crossed expected %b actual %b", want.marks_crossed, marks_crossed);
              err_cnt++;
            end
          end
        end
      end
    end
  end

  task automatic queue_request(input logic [CmdW-1:0] cmd, input logic [AddrW-1:0] size,
                               input logic [AddrW-1:0] arg);
    heap_request_t r;
    r.command = cmd;
    r.alloc_size = size;
    r.address_arg = arg;
    pending_requests.push_back(r);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_outcomes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ram_end(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RegRamEndAddr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [AddrW-1:0] pick_size();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 4) return $urandom;
    return $urandom_range(0, 4096);
  endfunction

  function automatic logic [AddrW-1:0] pick_align();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return $urandom;
    if (r == 2) return $urandom_range(1, 1000);
    if (r < 5) return 32'd1 << $urandom_range(13, 31);
    return 32'd1 << $urandom_range(0, 12);
  endfunction

  task automatic run_random_phase(input int count);
    int               n;
    int               len;
    logic [CmdW-1:0]  cmd;
    logic [AddrW-1:0] arg;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 7) == 0) begin
        queue_request(CmdW'($urandom_range(0, 7)), $urandom, $urandom);
        n++;
      end else begin
        arg = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0001_0000);
        queue_request(CMD_INIT, pick_size(), arg);
        n++;
        len = $urandom_range(3, 30);
        for (int k = 0; k < len; k++) begin
          cmd = CmdW'($urandom_range(1, 6));
          case (cmd)
            CMD_ALLOC_ABOVE:
              arg = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0020_0000);
            CMD_LOW_ALIGNED, CMD_HIGH_ALIGNED: arg = pick_align();
            default: arg = $urandom;
          endcase
          queue_request(cmd, pick_size(), arg);
          n++;
        end
      end
    end
  endtask

  initial begin
    logic [31:0] ram_end_settings[5];
    ram_end_settings = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0010_0000, $urandom, 32'h8000_0000};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // before any init, marks still at zero
    queue_request(CMD_QUERY, 32'd0, 32'd0);
    queue_request(CMD_ALLOC_LOW, 32'd100, 32'd0);
    queue_request(CmdUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();
    write_ram_end(32'h0010_0000);
    queue_request(CMD_INIT, 32'h0000_0234, 32'h0000_1000);
    queue_request(CMD_ALLOC_LOW, 32'd0, 32'd0);
    queue_request(CMD_ALLOC_LOW, 32'd1, 32'd0);
    queue_request(CMD_ALLOC_ABOVE, 32'd16, 32'h0000_8001);
    queue_request(CMD_ALLOC_ABOVE, 32'd64, 32'd0);
    queue_request(CMD_ALLOC_HIGH, 32'd0, 32'd0);
    queue_request(CMD_ALLOC_HIGH, 32'd100, 32'd0);
    queue_request(CMD_LOW_ALIGNED, 32'd10, 32'd4096);
    queue_request(CMD_HIGH_ALIGNED, 32'd300, 32'd256);
    // zero and unit alignment
    queue_request(CMD_LOW_ALIGNED, 32'd77, 32'd0);
    queue_request(CMD_HIGH_ALIGNED, 32'd5, 32'd0);
    queue_request(CMD_LOW_ALIGNED, 32'd3, 32'd1);
    // alignment not a power of two, then the top-bit alignment
    queue_request(CMD_HIGH_ALIGNED, 32'd9, 32'd3);
    queue_request(CMD_LOW_ALIGNED, 32'd1, 32'h8000_0000);
    queue_request(CMD_INIT, 32'd0, 32'd0);
    // wrap and crossed marks
    queue_request(CMD_ALLOC_LOW, 32'hFFFF_FFFF, 32'd0);
    queue_request(CMD_ALLOC_HIGH, 32'hFFFF_FFFF, 32'd0);
    queue_request(CMD_ALLOC_ABOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(CmdUnused, 32'd0, 32'd0);
    queue_request(CMD_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(CMD_HIGH_ALIGNED, 32'd0, 32'hFFFF_FFFF);

    foreach (ram_end_settings[i]) begin
      wait_drained();
      write_ram_end(ram_end_settings[i]);
      run_random_phase(200);
    end
    wait_drained();
    repeat (10) @(negedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
